/* rtl/gzhs_pkg.sv */
package gzhs_pkg;

	localparam logic [7:0] MAGIC0      = 8'h1f;
	localparam logic [7:0] MAGIC1      = 8'h8b;
	localparam logic [7:0] METHOD_DEFL = 8'h08;
	localparam logic [7:0] FLG_CONT    = 8'h02;
	localparam logic [7:0] FLG_EXTRA   = 8'h04;
	localparam logic [7:0] FLG_NAME    = 8'h08;
	localparam logic [7:0] FLG_COMMENT = 8'h10;
	localparam logic [7:0] FLG_ENCRYPT = 8'h20;
	localparam logic [7:0] FLG_RSVD    = 8'hc0;
	localparam logic [7:0] FLG_REJECT  = FLG_RSVD | FLG_ENCRYPT | FLG_CONT;

	localparam logic [2:0] FIXED_LEN   = 3'd6;

	localparam logic [2:0] PEND_EXTRA   = 3'b001;
	localparam logic [2:0] PEND_NAME    = 3'b010;
	localparam logic [2:0] PEND_COMMENT = 3'b100;

	typedef enum logic [1:0] {
		ST_HEADER  = 2'd0,
		ST_PAYLOAD = 2'd1,
		ST_ERROR   = 2'd2
	} status_t;

	typedef struct packed {
		logic       header_done;
		status_t    status;
		logic [7:0] payload_byte;
	} result_t;

endpackage

/* rtl/gzhs_parser.sv */
module gzhs_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          data_byte,
	input  logic                end_of_input,
	output gzhs_pkg::result_t   result
);

	typedef enum logic [3:0] {
		PH_MAGIC0  = 4'd0,
		PH_MAGIC1  = 4'd1,
		PH_METHOD  = 4'd2,
		PH_FLAGS   = 4'd3,
		PH_FIXED   = 4'd4,
		PH_XLEN_LO = 4'd5,
		PH_XLEN_HI = 4'd6,
		PH_XDATA   = 4'd7,
		PH_NAME    = 4'd8,
		PH_COMMENT = 4'd9,
		PH_PAYLOAD = 4'd10
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [2:0]  fixed_q, fixed_d;
	logic [15:0] extra_q, extra_d;
	logic [2:0]  pend_q, pend_d;
	logic        error_q, error_d;

	function automatic phase_t next_part(input logic [2:0] pend);
		phase_t ph;
		priority if ((pend & gzhs_pkg::PEND_EXTRA) != 3'd0) ph = PH_XLEN_LO;
		else if ((pend & gzhs_pkg::PEND_NAME) != 3'd0) ph = PH_NAME;
		else if ((pend & gzhs_pkg::PEND_COMMENT) != 3'd0) ph = PH_COMMENT;
		else ph = PH_PAYLOAD;
		return ph;
	endfunction

	always_comb begin
		logic        bad;
		logic [2:0]  cnt;
		logic [15:0] len;
		logic [2:0]  pend;
		bad     = 1'b0;
		cnt     = fixed_q + 3'd1;
		len     = 16'd0;
		pend    = pend_q;
		phase_d = phase_q;
		fixed_d = fixed_q;
		extra_d = extra_q;
		pend_d  = pend_q;
		error_d = error_q;
		result  = '{header_done: 1'b0, status: gzhs_pkg::ST_HEADER, payload_byte: 8'd0};
		if (error_q) begin
			result.status = gzhs_pkg::ST_ERROR;
		end else if (phase_q == PH_PAYLOAD) begin
			result.header_done = 1'b1;
			if (!end_of_input) begin
				result.status       = gzhs_pkg::ST_PAYLOAD;
				result.payload_byte = data_byte;
			end
		end else begin
			if (end_of_input) begin
				bad = 1'b1;
			end else begin
				unique case (phase_q)
					PH_MAGIC0: begin
						if (data_byte != gzhs_pkg::MAGIC0) bad = 1'b1;
						else phase_d = PH_MAGIC1;
					end
					PH_MAGIC1: begin
						if (data_byte != gzhs_pkg::MAGIC1) bad = 1'b1;
						else phase_d = PH_METHOD;
					end
					PH_METHOD: begin
						if (data_byte != gzhs_pkg::METHOD_DEFL) bad = 1'b1;
						else phase_d = PH_FLAGS;
					end
					PH_FLAGS: begin
						if ((data_byte & gzhs_pkg::FLG_REJECT) != 8'd0) begin
							bad = 1'b1;
						end else begin
							pend_d  = {(data_byte & gzhs_pkg::FLG_COMMENT) != 8'd0,
								(data_byte & gzhs_pkg::FLG_NAME) != 8'd0,
								(data_byte & gzhs_pkg::FLG_EXTRA) != 8'd0};
							fixed_d = 3'd0;
							phase_d = PH_FIXED;
						end
					end
					PH_FIXED: begin
						if (cnt >= gzhs_pkg::FIXED_LEN) begin
							fixed_d = 3'd0;
							phase_d = next_part(pend_q);
						end else begin
							fixed_d = cnt;
						end
					end
					PH_XLEN_LO: begin
						extra_d = {8'd0, data_byte};
						phase_d = PH_XLEN_HI;
					end
					PH_XLEN_HI: begin
						len     = {data_byte, extra_q[7:0]};
						extra_d = len;
						if (len == 16'd0) begin
							pend    = pend_q & ~gzhs_pkg::PEND_EXTRA;
							pend_d  = pend;
							phase_d = next_part(pend);
						end else begin
							phase_d = PH_XDATA;
						end
					end
					PH_XDATA: begin
						len     = extra_q - 16'd1;
						extra_d = len;
						if (len == 16'd0) begin
							pend    = pend_q & ~gzhs_pkg::PEND_EXTRA;
							pend_d  = pend;
							phase_d = next_part(pend);
						end
					end
					PH_NAME: begin
						if (data_byte == 8'd0) begin
							pend    = pend_q & ~gzhs_pkg::PEND_NAME;
							pend_d  = pend;
							phase_d = next_part(pend);
						end
					end
					PH_COMMENT: begin
						if (data_byte == 8'd0) begin
							pend    = pend_q & ~gzhs_pkg::PEND_COMMENT;
							pend_d  = pend;
							phase_d = next_part(pend);
						end
					end
					default: bad = 1'b1;
				endcase
			end
			if (bad) begin
				error_d       = 1'b1;
				phase_d       = phase_q;
				fixed_d       = fixed_q;
				extra_d       = extra_q;
				pend_d        = pend_q;
				result.status = gzhs_pkg::ST_ERROR;
			end else begin
				result.header_done = (phase_d == PH_PAYLOAD);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC0;
			fixed_q <= 3'd0;
			extra_q <= 16'd0;
			pend_q  <= 3'd0;
			error_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			fixed_q <= fixed_d;
			extra_q <= extra_d;
			pend_q  <= pend_d;
			error_q <= error_d;
		end
	end

`ifndef SYNTHESIS
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		error_q |=> error_q)
		else $error("format error cleared without reset");
	a_payload_stays: assert property (@(posedge clk) disable iff (!arst_n)
		advance && phase_q == PH_PAYLOAD && !error_q |=> phase_q == PH_PAYLOAD)
		else $error("left payload phase");
	a_payload_phase: assert property (@(posedge clk) disable iff (!arst_n)
		result.status == gzhs_pkg::ST_PAYLOAD |-> phase_q == PH_PAYLOAD && !error_q)
		else $error("payload passed during header");
	a_fixed_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FIXED |-> fixed_q < gzhs_pkg::FIXED_LEN)
		else $error("fixed skip count out of range");
`endif

endmodule

/* rtl/gzip_header_skipper.sv */
// Each accepted input beat gives its result beat in the cycle after it is taken.
// Throughput: one beat per cycle; input is taken whenever the output
// register is empty or being drained in the same cycle.
// Reset (arst_n low, asynchronous): parser expects the first magic byte,
// the sticky error clears and the output register empties.
module gzip_header_skipper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // end_of_input
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] payload_byte
	output logic [2:0] m_tuser    // [1:0] status, [2] header_done
);

	logic              accept;
	logic              m_valid_q;
	logic [7:0]        m_data_q;
	logic [2:0]        m_user_q;
	gzhs_pkg::result_t result;

	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	gzhs_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (accept),
		.data_byte    (s_tdata),
		.end_of_input (s_tlast),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_tready) begin
			m_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= result.payload_byte;
			m_user_q <= {result.header_done, result.status};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

`ifndef SYNTHESIS
	a_beat_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted beat produced no result");
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> !$past(accept))
		else $error("input taken while result stalled");
	a_error_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == gzhs_pkg::ST_ERROR |-> !m_tuser[2] && m_tdata == 8'd0)
		else $error("error beat carries done or data");
`endif

endmodule
